>>> rtl/assert_macros.svh
// Assertion helpers for the RTL file that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error(msg);

// Next-cycle implication, sampled on clk and switched off during reset.
`define ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> cons) \
		else $error(msg);

`endif

>>> rtl/m3i_pkg.sv
package m3i_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int DW    = 32;   // entry width
	localparam int CW    = 65;   // cofactor width
	localparam int DETW  = 100;  // exact determinant width
	localparam int NUMW  = 128;  // shifted numerator width
	localparam int HIW   = 96;   // numerator above the quotient bits
	localparam int QB    = 32;   // quotient bits produced by the divider
	localparam int NL    = 9;    // matrix entries
	localparam int ADJ_LAT = 2;
	localparam int DET_LAT = 3;
	localparam int DIV_LAT = QB + 3;
	localparam int TOTAL_LAT = ADJ_LAT + DET_LAT + DIV_LAT;

	typedef logic signed [DW-1:0]   word_t;
	typedef logic signed [CW-1:0]   cof_t;
	typedef logic signed [DETW-1:0] det_t;
	typedef logic [DETW-1:0]        mag_t;

	// Saturate a quotient magnitude with its sign to 32 bits.
	function automatic logic [DW-1:0] sat32(input logic [QB-1:0] q, input logic ovf,
		input logic neg);
		logic [DW-1:0] r;
		if (!neg) begin
			r = (ovf || q[QB-1]) ? 32'h7FFF_FFFF : q;
		end else begin
			r = (ovf || q > 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - q);
		end
		return r;
	endfunction
endpackage

>>> rtl/m3i_adj.sv
module m3i_adj import m3i_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  vin,
	input  word_t m [NL],
	output logic  vout,
	output word_t row0 [3],
	output cof_t  cof [NL]
);
	logic                 vld_s1;
	logic signed [63:0]   pa_s1 [NL];
	logic signed [63:0]   pb_s1 [NL];
	word_t                row_s1 [3];
	logic                 vld_s2;
	cof_t                 cof_s2 [NL];
	word_t                row_s2 [3];

	for (genvar g = 0; g < NL; g++) begin : g_min
		localparam int I  = g / 3;
		localparam int J  = g % 3;
		localparam int R0 = (I == 0) ? 1 : 0;
		localparam int R1 = (I == 2) ? 1 : 2;
		localparam int C0 = (J == 0) ? 1 : 0;
		localparam int C1 = (J == 2) ? 1 : 2;
		logic signed [CW-1:0] diff;
		always_ff @(posedge clk) begin
			pa_s1[g] <= 64'(m[R0*3+C0]) * 64'(m[R1*3+C1]);
			pb_s1[g] <= 64'(m[R0*3+C1]) * 64'(m[R1*3+C0]);
		end
		assign diff = CW'(pa_s1[g]) - CW'(pb_s1[g]);
		// Checkerboard sign on odd row plus column.
		always_ff @(posedge clk) begin
			cof_s2[g] <= ((I + J) % 2 == 1) ? -diff : diff;
		end
	end

	always_ff @(posedge clk) begin
		row_s1 <= m[0:2];
		row_s2 <= row_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= vin;
			vld_s2 <= vld_s1;
		end
	end

	assign vout = vld_s2;
	assign row0 = row_s2;
	assign cof  = cof_s2;
endmodule

>>> rtl/m3i_det.sv
module m3i_det import m3i_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  vin,
	input  word_t row0 [3],
	input  cof_t  cof [NL],
	output logic  vout,
	output det_t  det,
	output cof_t  cof_out [NL]
);
	logic                 vld_s1, vld_s2, vld_s3;
	logic signed [CW-1:0] pl_s1 [3];
	logic signed [CW-1:0] ph_s1 [3];
	det_t                 t_s2 [3];
	det_t                 det_s3;
	cof_t                 cof_s1 [NL];
	cof_t                 cof_s2 [NL];
	cof_t                 cof_s3 [NL];

	// Each 32 by 65 product is split into two 32 by 33 halves.
	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			pl_s1[j] <= CW'(row0[j]) * CW'($signed({1'b0, cof[j][31:0]}));
			ph_s1[j] <= CW'(row0[j]) * CW'($signed(cof[j][CW-1:32]));
			t_s2[j]  <= (DETW'(ph_s1[j]) <<< 32) + DETW'(pl_s1[j]);
		end
		det_s3 <= t_s2[0] + t_s2[1] + t_s2[2];
		cof_s1 <= cof;
		cof_s2 <= cof_s1;
		cof_s3 <= cof_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= vin;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	assign vout    = vld_s3;
	assign det     = det_s3;
	assign cof_out = cof_s3;
endmodule

>>> rtl/m3i_div.sv
module m3i_div import m3i_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vin,
	input  det_t          det,
	input  cof_t          cof [NL],
	output logic          vout,
	output logic [DW-1:0] inv [NL],
	output logic [DW-1:0] det_value,
	output logic          singular
);
	// Front stage: magnitudes and shifted numerators.
	logic                vld_s1;
	mag_t                dmag_s1;
	logic                sing_s1;
	logic [DW-1:0]       detv_s1;
	logic [HIW-1:0]      hi_s1 [NL];
	logic [QB-1:0]       lo_s1 [NL];
	logic                neg_s1 [NL];

	// Division stages, index 0 is the overflow check stage.
	logic                vld_s [QB+1];
	mag_t                dmag_s [QB+1];
	logic                sing_s [QB+1];
	logic [DW-1:0]       detv_s [QB+1];
	logic [DETW-1:0]     rem_s [QB+1][NL];
	logic [QB-1:0]       quo_s [QB+1][NL];
	logic [QB-1:0]       lo_s [QB+1][NL];
	logic                ovf_s [QB+1][NL];
	logic                neg_s [QB+1][NL];

	logic                vld_o;
	logic [DW-1:0]       inv_o [NL];
	logic [DW-1:0]       detv_o;
	logic                sing_o;

	logic                dneg;
	mag_t                dmag;
	mag_t                dq;

	assign dneg = det[DETW-1];
	assign dmag = dneg ? mag_t'(-det) : mag_t'(det);
	assign dq   = dmag >> (2 * FRAC_BITS);

	for (genvar l = 0; l < NL; l++) begin : g_num
		localparam int SRC = (l % 3) * 3 + l / 3;  // adjugate is the transpose
		logic [CW-1:0]   amw;
		logic [NUMW-1:0] num;
		assign amw = cof[SRC][CW-1] ? CW'(-cof[SRC]) : CW'(cof[SRC]);
		assign num = NUMW'(amw[63:0]) << (2 * FRAC_BITS);
		always_ff @(posedge clk) begin
			hi_s1[l]  <= num[NUMW-1:QB];
			lo_s1[l]  <= num[QB-1:0];
			neg_s1[l] <= cof[SRC][CW-1] ^ dneg;
		end
	end

	always_ff @(posedge clk) begin
		dmag_s1 <= dmag;
		sing_s1 <= (det == '0);
		detv_s1 <= sat32(dq[QB-1:0], |dq[DETW-1:QB], dneg);
		dmag_s[0] <= dmag_s1;
		sing_s[0] <= sing_s1;
		detv_s[0] <= detv_s1;
		for (int l = 0; l < NL; l++) begin
			// A quotient of 2^32 or more saturates in any case.
			ovf_s[0][l] <= {4'b0, hi_s1[l]} >= dmag_s1;
			rem_s[0][l] <= DETW'(hi_s1[l]);
			quo_s[0][l] <= '0;
			lo_s[0][l]  <= lo_s1[l];
			neg_s[0][l] <= neg_s1[l];
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_stage
		logic [DETW:0]   sh [NL];
		logic [DETW+1:0] df [NL];
		always_comb begin
			for (int l = 0; l < NL; l++) begin
				sh[l] = {rem_s[k][l], lo_s[k][l][QB-1-k]};
				df[l] = {1'b0, sh[l]} - {2'b0, dmag_s[k]};
			end
		end
		always_ff @(posedge clk) begin
			dmag_s[k+1] <= dmag_s[k];
			sing_s[k+1] <= sing_s[k];
			detv_s[k+1] <= detv_s[k];
			for (int l = 0; l < NL; l++) begin
				rem_s[k+1][l] <= df[l][DETW+1] ? sh[l][DETW-1:0] : df[l][DETW-1:0];
				quo_s[k+1][l] <= {quo_s[k][l][QB-2:0], ~df[l][DETW+1]};
				lo_s[k+1][l]  <= lo_s[k][l];
				ovf_s[k+1][l] <= ovf_s[k][l];
				neg_s[k+1][l] <= neg_s[k][l];
			end
		end
	end

	always_ff @(posedge clk) begin
		sing_o <= sing_s[QB];
		detv_o <= sing_s[QB] ? '0 : detv_s[QB];
		for (int l = 0; l < NL; l++) begin
			inv_o[l] <= sing_s[QB] ? '0 :
				sat32(quo_s[QB][l], ovf_s[QB][l], neg_s[QB][l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_o  <= 1'b0;
			for (int k = 0; k <= QB; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else begin
			vld_s1   <= vin;
			vld_s[0] <= vld_s1;
			for (int k = 0; k < QB; k++) begin
				vld_s[k+1] <= vld_s[k];
			end
			vld_o <= vld_s[QB];
		end
	end

	assign vout      = vld_o;
	assign inv       = inv_o;
	assign det_value = detv_o;
	assign singular  = sing_o;
endmodule

>>> rtl/matrix3_inverse.sv
// Channel   Handshake        Transfer
// input     start / busy     m00 .. m22, one matrix in row-major order
// result    done (strobe)    inv00 .. inv22, det_value, singular
//
// A matrix may be started in every cycle; busy is always low.
// Each matrix passes the adjugate, determinant and divider stages, the last a 32-stage
// restoring divider that yields one quotient bit per stage for nine lanes.
// Reset clears only the valid bits of the pipeline; no results are pending after it.
// The receiver cannot stall, so done is a one-cycle strobe per result.
module matrix3_inverse import m3i_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic [DW-1:0] m00,
	input  logic [DW-1:0] m01,
	input  logic [DW-1:0] m02,
	input  logic [DW-1:0] m10,
	input  logic [DW-1:0] m11,
	input  logic [DW-1:0] m12,
	input  logic [DW-1:0] m20,
	input  logic [DW-1:0] m21,
	input  logic [DW-1:0] m22,
	output logic          done,
	output logic [DW-1:0] inv00,
	output logic [DW-1:0] inv01,
	output logic [DW-1:0] inv02,
	output logic [DW-1:0] inv10,
	output logic [DW-1:0] inv11,
	output logic [DW-1:0] inv12,
	output logic [DW-1:0] inv20,
	output logic [DW-1:0] inv21,
	output logic [DW-1:0] inv22,
	output logic [DW-1:0] det_value,
	output logic          singular
);
	`include "assert_macros.svh"

	word_t         mat [NL];
	word_t         row0 [3];
	cof_t          cof_a [NL];
	cof_t          cof_d [NL];
	det_t          det;
	logic          v_adj, v_det;
	logic [DW-1:0] inv [NL];

	// The pipeline never stalls, so the input side is always open.
	assign busy = 1'b0;

	assign mat[0] = m00;
	assign mat[1] = m01;
	assign mat[2] = m02;
	assign mat[3] = m10;
	assign mat[4] = m11;
	assign mat[5] = m12;
	assign mat[6] = m20;
	assign mat[7] = m21;
	assign mat[8] = m22;

	// Minors and signed cofactors.
	m3i_adj u_adj (
		.clk(clk), .arst_n(arst_n), .vin(start && !busy), .m(mat),
		.vout(v_adj), .row0(row0), .cof(cof_a)
	);

	// Determinant by expansion along the first row.
	m3i_det u_det (
		.clk(clk), .arst_n(arst_n), .vin(v_adj), .row0(row0), .cof(cof_a),
		.vout(v_det), .det(det), .cof_out(cof_d)
	);

	// Adjugate divided by the determinant, with saturation.
	m3i_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .vin(v_det), .det(det), .cof(cof_d),
		.vout(done), .inv(inv), .det_value(det_value), .singular(singular)
	);

	assign inv00 = inv[0];
	assign inv01 = inv[1];
	assign inv02 = inv[2];
	assign inv10 = inv[3];
	assign inv11 = inv[4];
	assign inv12 = inv[5];
	assign inv20 = inv[6];
	assign inv21 = inv[7];
	assign inv22 = inv[8];

	// A result comes out exactly when a matrix went in the fixed latency earlier.
	`ASSERT_IMP(a_done_lat, done, $past(start && !busy, TOTAL_LAT), "done without start")
	`ASSERT_IMP(a_start_lat, $past(start && !busy, TOTAL_LAT), done, "start lost")
	// A singular result carries an all-zero inverse and determinant.
	`ASSERT_IMP(a_sing_zero, done && singular,
		det_value == '0 && inv00 == '0 && inv11 == '0 && inv22 == '0, "singular not zeroed")
endmodule
